// ===== rtl/lz77w_pkg.sv =====
// Shared types, constants and codes for the LZ77 window decompressor.
package lz77w_pkg;

	// History window and length field sizes
	localparam int HISTORY_DEPTH = 4096;
	localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
	localparam int LENGTH_BITS   = 24;
	localparam int MIN_MATCH     = 3;
	localparam int RUN_W         = 5;	// holds a copy length up to 18
	localparam int DISP_W        = 13;	// holds a distance up to 4096

	// Header type nibble expected in the first header byte
	localparam logic [3:0] HDR_TYPE = 4'h1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_HEADER = 2'd1,
		ST_FAR        = 2'd2,
		ST_TRUNC      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_FLAG,
		PH_UNIT,
		PH_MATCH2,
		PH_COPY,
		PH_DRAIN
	} phase_t;

	// Input transaction
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	// Output transaction
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       run_last;
		logic       stream_done;
		status_t    status;
	} out_item_t;

	// One result issued by the parser towards the history stage
	typedef struct packed {
		logic               valid;
		logic               has_byte;
		logic               from_mem;
		logic [7:0]         lit_byte;
		logic               run_last;
		logic               done;
		status_t            status;
		logic [HIST_AW-1:0] wr_addr;
	} issue_t;

endpackage

// ===== rtl/lz77w_hist_ram.sv =====
// Simple dual-port history RAM with a registered read port.
module lz77w_hist_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/lz77w_ctrl.sv =====
// Stream parser and back-reference copy sequencer.
module lz77w_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  lz77w_pkg::in_item_t                  item,
	input  logic                                 issue_ok,
	output lz77w_pkg::issue_t                    iss,
	output logic                                 rd_en,
	output logic [lz77w_pkg::HIST_AW-1:0]        rd_addr
);

	localparam int LB = lz77w_pkg::LENGTH_BITS;
	localparam int AW = lz77w_pkg::HIST_AW;
	localparam int RW = lz77w_pkg::RUN_W;
	localparam int DW = lz77w_pkg::DISP_W;

	lz77w_pkg::phase_t phase_q, phase_d;
	logic [1:0]    hdr_idx_q, hdr_idx_d;
	logic [15:0]   len_lo_q, len_lo_d;
	logic [LB-1:0] exp_q, exp_d;
	logic [LB-1:0] prod_q, prod_d;
	logic [7:0]    flags_q, flags_d;
	logic [2:0]    unit_q, unit_d;
	logic [7:0]    held_q, held_d;
	logic [RW-1:0] rem_q, rem_d;
	logic [AW-1:0] src_q, src_d;
	logic          clast_q, clast_d;

	logic          take;
	logic [7:0]    b;
	logic          last;
	logic [23:0]   len_full;
	logic [RW-1:0] m_len;
	logic [DW-1:0] m_disp;
	logic [LB-1:0] room;
	logic [LB-1:0] prod_inc;
	logic          do_after, after_last;
	logic          end_now, end_last;

	assign b        = item.in_byte;
	assign last     = item.in_last;
	assign len_full = {b, len_lo_q};
	assign m_len    = RW'({1'b0, held_q[7:4]}) + RW'(lz77w_pkg::MIN_MATCH);
	assign m_disp   = DW'({held_q[3:0], b}) + DW'(1);
	assign room     = exp_q - prod_q;
	assign prod_inc = prod_q + LB'(1);

	assign item_stall = (phase_q == lz77w_pkg::PH_COPY) || !issue_ok;
	assign take       = item_valid && !item_stall;

	// Next state and issued result
	always_comb begin
		phase_d    = phase_q;
		hdr_idx_d  = hdr_idx_q;
		len_lo_d   = len_lo_q;
		exp_d      = exp_q;
		prod_d     = prod_q;
		flags_d    = flags_q;
		unit_d     = unit_q;
		held_d     = held_q;
		rem_d      = rem_q;
		src_d      = src_q;
		clast_d    = clast_q;
		iss        = '0;
		iss.status = lz77w_pkg::ST_OK;
		rd_en      = 1'b0;
		rd_addr    = src_q;
		do_after   = 1'b0;
		after_last = 1'b0;
		end_now    = 1'b0;
		end_last   = 1'b0;

		case (phase_q)
			lz77w_pkg::PH_HEADER: begin
				if (take) begin
					if (hdr_idx_q == 2'd0 && b[7:4] != lz77w_pkg::HDR_TYPE) begin
						iss.valid  = 1'b1;
						iss.done   = 1'b1;
						iss.status = lz77w_pkg::ST_BAD_HEADER;
						end_now    = 1'b1;
						end_last   = last;
					end else if (hdr_idx_q == 2'd3) begin
						exp_d     = len_full[LB-1:0];
						hdr_idx_d = 2'd0;
						phase_d   = lz77w_pkg::PH_FLAG;
						if (len_full[LB-1:0] == '0) begin
							iss.valid = 1'b1;
							iss.done  = 1'b1;
							end_now   = 1'b1;
							end_last  = last;
						end else if (last) begin
							iss.valid  = 1'b1;
							iss.done   = 1'b1;
							iss.status = lz77w_pkg::ST_TRUNC;
							end_now    = 1'b1;
							end_last   = 1'b1;
						end
					end else begin
						if (hdr_idx_q == 2'd1) begin
							len_lo_d[7:0] = b;
						end
						if (hdr_idx_q == 2'd2) begin
							len_lo_d[15:8] = b;
						end
						hdr_idx_d = hdr_idx_q + 2'd1;
						if (last) begin
							iss.valid  = 1'b1;
							iss.done   = 1'b1;
							iss.status = lz77w_pkg::ST_TRUNC;
							end_now    = 1'b1;
							end_last   = 1'b1;
						end
					end
				end
			end
			lz77w_pkg::PH_FLAG: begin
				if (take) begin
					flags_d = b;
					unit_d  = 3'd0;
					phase_d = lz77w_pkg::PH_UNIT;
					if (last) begin
						iss.valid  = 1'b1;
						iss.done   = 1'b1;
						iss.status = lz77w_pkg::ST_TRUNC;
						end_now    = 1'b1;
						end_last   = 1'b1;
					end
				end
			end
			lz77w_pkg::PH_UNIT: begin
				if (take) begin
					if (flags_q[3'd7 - unit_q]) begin
						held_d  = b;
						phase_d = lz77w_pkg::PH_MATCH2;
						if (last) begin
							iss.valid  = 1'b1;
							iss.done   = 1'b1;
							iss.status = lz77w_pkg::ST_TRUNC;
							end_now    = 1'b1;
							end_last   = 1'b1;
						end
					end else begin
						// literal byte
						iss.valid    = 1'b1;
						iss.has_byte = 1'b1;
						iss.lit_byte = b;
						iss.run_last = 1'b1;
						iss.wr_addr  = prod_q[AW-1:0];
						prod_d       = prod_inc;
						do_after     = 1'b1;
						after_last   = last;
					end
				end
			end
			lz77w_pkg::PH_MATCH2: begin
				if (take) begin
					if (LB'(m_disp) > prod_q) begin
						iss.valid  = 1'b1;
						iss.done   = 1'b1;
						iss.status = lz77w_pkg::ST_FAR;
						end_now    = 1'b1;
						end_last   = last;
					end else begin
						// copy length cut at the expected length
						rem_d   = (LB'(m_len) > room) ? room[RW-1:0] : m_len;
						src_d   = prod_q[AW-1:0] - m_disp[AW-1:0];
						clast_d = last;
						phase_d = lz77w_pkg::PH_COPY;
					end
				end
			end
			lz77w_pkg::PH_COPY: begin
				// one history read per output byte
				if (issue_ok) begin
					rd_en        = 1'b1;
					iss.valid    = 1'b1;
					iss.has_byte = 1'b1;
					iss.from_mem = 1'b1;
					iss.wr_addr  = prod_q[AW-1:0];
					prod_d       = prod_inc;
					src_d        = src_q + AW'(1);
					rem_d        = rem_q - RW'(1);
					if (rem_q == RW'(1)) begin
						iss.run_last = 1'b1;
						do_after     = 1'b1;
						after_last   = clast_q;
					end
				end
			end
			lz77w_pkg::PH_DRAIN: begin
				if (take && last) begin
					end_now  = 1'b1;
					end_last = 1'b1;
				end
			end
			default: begin
				phase_d = lz77w_pkg::PH_HEADER;
			end
		endcase

		// A result without a byte is the only one of its input byte
		if (iss.valid && !iss.has_byte) begin
			iss.run_last = 1'b1;
		end

		// End of a unit: completion, next flag bit, or truncation
		if (do_after) begin
			if (prod_inc >= exp_q) begin
				iss.done = 1'b1;
				end_now  = 1'b1;
				end_last = after_last;
			end else begin
				unit_d  = unit_q + 3'd1;
				phase_d = (unit_q == 3'd7) ? lz77w_pkg::PH_FLAG : lz77w_pkg::PH_UNIT;
				if (after_last) begin
					iss.done   = 1'b1;
					iss.status = lz77w_pkg::ST_TRUNC;
					end_now    = 1'b1;
					end_last   = 1'b1;
				end
			end
		end

		// Stream end: restart on the last input byte, else drain
		if (end_now) begin
			if (end_last) begin
				phase_d   = lz77w_pkg::PH_HEADER;
				hdr_idx_d = 2'd0;
				exp_d     = '0;
				prod_d    = '0;
				flags_d   = '0;
				unit_d    = 3'd0;
				held_d    = '0;
			end else begin
				phase_d = lz77w_pkg::PH_DRAIN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lz77w_pkg::PH_HEADER;
			hdr_idx_q <= 2'd0;
			len_lo_q  <= '0;
			exp_q     <= '0;
			prod_q    <= '0;
			flags_q   <= '0;
			unit_q    <= 3'd0;
			held_q    <= '0;
			rem_q     <= '0;
			src_q     <= '0;
			clast_q   <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			len_lo_q  <= len_lo_d;
			exp_q     <= exp_d;
			prod_q    <= prod_d;
			flags_q   <= flags_d;
			unit_q    <= unit_d;
			held_q    <= held_d;
			rem_q     <= rem_d;
			src_q     <= src_d;
			clast_q   <= clast_d;
		end
	end

endmodule

// ===== rtl/lz77_window_decompressor.sv =====
// Top level: parser, history RAM stage with forwarding, and output register.
//
//  channel | valid      | stall      | payload               | carries
//  input   | item_valid | item_stall | item  (in_item_t)     | one compressed byte
//  output  | res_valid  | res_stall  | res   (out_item_t)    | one result
//
// Header, flag and literal bytes are each taken without a wait unless an output
// stall holds them. The second byte of a back reference starts a copy of up to
// 18 bytes, with the input stalled and one read of the single history port per output byte.
// Reset is asynchronous and clears control state only; the history RAM is not
// cleared and is only read at entries written by the current stream.
// A stall on the output holds the history stage and the copy sequencer.
module lz77_window_decompressor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  lz77w_pkg::in_item_t  item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output lz77w_pkg::out_item_t res
);

	localparam int AW = lz77w_pkg::HIST_AW;

	lz77w_pkg::issue_t iss;
	lz77w_pkg::issue_t s1_q;
	logic              s1_valid_q;
	logic              issue_ok;
	logic              advance;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [7:0]        rd_data;
	logic              wr_en;
	logic [7:0]        s1_byte;
	logic              fwd_s1;
	logic [7:0]        fwd_byte_s1;
	logic              res_valid_q;
	lz77w_pkg::out_item_t res_q;

	assign advance  = !res_valid_q || !res_stall;
	assign issue_ok = !s1_valid_q || advance;

	lz77w_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.issue_ok   (issue_ok),
		.iss        (iss),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr)
	);

	// Byte of the history stage: literal, RAM data, or forwarded write
	always_comb begin
		if (!s1_q.from_mem) begin
			s1_byte = s1_q.lit_byte;
		end else if (fwd_s1) begin
			s1_byte = fwd_byte_s1;
		end else begin
			s1_byte = rd_data;
		end
	end

	assign wr_en = s1_valid_q && advance && s1_q.has_byte;

	lz77w_hist_ram #(
		.ADDR_W (AW),
		.DATA_W (8)
	) u_hist (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (s1_q.wr_addr),
		.wr_data (s1_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Forward the byte being written when a read hits the same entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_s1      <= wr_en && (rd_addr == s1_q.wr_addr);
			fwd_byte_s1 <= s1_byte;
		end
	end

	// History stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (issue_ok) begin
			s1_valid_q <= iss.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (issue_ok && iss.valid) begin
			s1_q <= iss;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			res_q.out_byte    <= s1_q.has_byte ? s1_byte : 8'd0;
			res_q.has_byte    <= s1_q.has_byte;
			res_q.run_last    <= s1_q.run_last;
			res_q.stream_done <= s1_q.done;
			res_q.status      <= s1_q.status;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
